[hdl/assert_macros.svh]
// Assertion macros for the RTL of the pixel converter.
// No dependencies; the bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Plain property checked on every rising clock edge outside reset.
`define RHSV_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rhsv assertion failed");

// Overlapping implication checked on every rising clock edge outside reset.
`define RHSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhsv implication failed");

// Next-cycle implication checked outside reset.
`define RHSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhsv next-cycle implication failed");

`else

`define RHSV_ASSERT(lbl, clk, rst_n, expr)
`define RHSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RHSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/rhsv_pkg.sv]
// Shared widths and pipeline geometry of the RGB-to-HSV pixel converter.
// No dependencies.
package rhsv_pkg;

  // Channel width of every input and result field
  localparam int PIX_W      = 8;
  // Dividends: 255*delta and 30*num both stay below 2**16
  localparam int DVD_W      = 2 * PIX_W;
  // Hue numerator lies in 0 .. 6*delta-1
  localparam int NUM_W      = PIX_W + 3;
  // One quotient bit per divider stage
  localparam int DIV_STEPS  = PIX_W;
  // Stages ahead of the dividers: sort, hue numerator, dividend setup
  localparam int PIPE_FRONT = 3;
  localparam int PIPE_DEPTH = PIPE_FRONT + DIV_STEPS;
  // Largest hue code, two-degree steps
  localparam logic [PIX_W-1:0] HUE_MAX = PIX_W'(179);

endpackage

[hdl/rhsv_if.sv]
// Valid/ready channel interfaces for RGB input beats and HSV result beats.
// Depends on rhsv_pkg for the channel width.
interface rhsv_rgb_if;
  logic                        valid;
  logic                        ready;
  logic [rhsv_pkg::PIX_W-1:0]  red;
  logic [rhsv_pkg::PIX_W-1:0]  green;
  logic [rhsv_pkg::PIX_W-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhsv_hsv_if;
  logic                        valid;
  logic                        ready;
  logic [rhsv_pkg::PIX_W-1:0]  hue;
  logic [rhsv_pkg::PIX_W-1:0]  saturation;
  logic [rhsv_pkg::PIX_W-1:0]  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

[hdl/rgb_to_hsv_pixel_unit.sv]
// RGB-to-HSV pixel converter: takes one 8-bit RGB beat per clock and returns
// hue (0..179, two-degree steps), saturation floor(255*(max-min)/max) and
// brightness max(r,g,b), exact integer results. Throughput is one beat per
// clock unless the output stalls; a beat passes three front stages (channel
// sort, hue numerator, dividend setup) and eight stages of two parallel
// restoring dividers, one quotient bit per stage, the last of which is the
// output register. Stages with no beat in them keep filling while the output
// is stalled, so input ready drops only when every stage is full.
// Depends on rhsv_pkg, rhsv_if, rhsv_div and assert_macros.svh.
`include "assert_macros.svh"

module rgb_to_hsv_pixel_unit (
  input  logic        clk,
  input  logic        rst_n,
  rhsv_rgb_if.sink    in_beat,
  rhsv_hsv_if.source  out_beat
);
  import rhsv_pkg::*;

  localparam int LAST = PIPE_DEPTH - 1;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sel_t;

  // ---------------------------------------------------------------- control
  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] en;

  // A stage may load when it is empty or the stage after it moves
  always_comb begin
    en[LAST] = !v_r[LAST] || out_beat.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_beat.valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_beat.ready  = en[0];
  assign out_beat.valid = v_r[LAST];

  // ---------------------------------------------------------- stage 1: sort
  logic [PIX_W-1:0] s1_red_r, s1_green_r, s1_blue_r, s1_hi_r, s1_lo_r;
  sel_t             s1_sel_r;
  logic [PIX_W-1:0] s1_hi_nxt, s1_lo_nxt;
  sel_t             s1_sel_nxt;

  // Ties go to red, then green
  always_comb begin
    if (in_beat.red >= in_beat.green && in_beat.red >= in_beat.blue) begin
      s1_sel_nxt = SEL_RED;
      s1_hi_nxt  = in_beat.red;
    end else if (in_beat.green >= in_beat.blue) begin
      s1_sel_nxt = SEL_GREEN;
      s1_hi_nxt  = in_beat.green;
    end else begin
      s1_sel_nxt = SEL_BLUE;
      s1_hi_nxt  = in_beat.blue;
    end
    s1_lo_nxt = (in_beat.red <= in_beat.green) ? in_beat.red : in_beat.green;
    if (in_beat.blue < s1_lo_nxt) begin
      s1_lo_nxt = in_beat.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_red_r   <= in_beat.red;
      s1_green_r <= in_beat.green;
      s1_blue_r  <= in_beat.blue;
      s1_hi_r    <= s1_hi_nxt;
      s1_lo_r    <= s1_lo_nxt;
      s1_sel_r   <= s1_sel_nxt;
    end
  end

  // ------------------------------------------------ stage 2: hue numerator
  logic [PIX_W-1:0] s2_delta_r, s2_hi_r;
  logic [NUM_W-1:0] s2_num_r;
  logic [PIX_W-1:0] s2_delta_nxt;
  logic [NUM_W-1:0] s2_num_nxt;
  logic [NUM_W-1:0] d_ext, r_ext, g_ext, b_ext;

  // Wraparound arithmetic: every case lands in 0 .. 6*delta-1
  always_comb begin
    s2_delta_nxt = s1_hi_r - s1_lo_r;
    d_ext = NUM_W'(s2_delta_nxt);
    r_ext = NUM_W'(s1_red_r);
    g_ext = NUM_W'(s1_green_r);
    b_ext = NUM_W'(s1_blue_r);
    case (s1_sel_r)
      SEL_RED: begin
        s2_num_nxt = g_ext - b_ext;
        if (s1_green_r < s1_blue_r) begin
          s2_num_nxt = s2_num_nxt + (d_ext << 2) + (d_ext << 1);
        end
      end
      SEL_GREEN: s2_num_nxt = b_ext - r_ext + (d_ext << 1);
      SEL_BLUE:  s2_num_nxt = r_ext - g_ext + (d_ext << 2);
      default:   s2_num_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_delta_r <= s2_delta_nxt;
      s2_num_r   <= s2_num_nxt;
      s2_hi_r    <= s1_hi_r;
    end
  end

  // ---------------------------------------------- stage 3: dividend setup
  logic [DVD_W-1:0] s3_sat_dvd_r, s3_hue_dvd_r;
  logic [PIX_W-1:0] s3_sat_dsr_r, s3_hue_dsr_r, s3_hi_r;
  logic [DVD_W-1:0] s3_sat_dvd_nxt, s3_hue_dvd_nxt;
  logic [PIX_W-1:0] s3_sat_dsr_nxt, s3_hue_dsr_nxt;

  // 255*delta and 30*num by shift and subtract; a zero divisor only comes
  // with a zero dividend, so it is swapped for one to give a zero quotient
  always_comb begin
    s3_sat_dvd_nxt = {s2_delta_r, {PIX_W{1'b0}}} - DVD_W'(s2_delta_r);
    s3_hue_dvd_nxt = (DVD_W'(s2_num_r) << 5) - (DVD_W'(s2_num_r) << 1);
    s3_sat_dsr_nxt = (s2_hi_r == '0) ? PIX_W'(1) : s2_hi_r;
    s3_hue_dsr_nxt = (s2_delta_r == '0) ? PIX_W'(1) : s2_delta_r;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_sat_dvd_r <= s3_sat_dvd_nxt;
      s3_hue_dvd_r <= s3_hue_dvd_nxt;
      s3_sat_dsr_r <= s3_sat_dsr_nxt;
      s3_hue_dsr_r <= s3_hue_dsr_nxt;
      s3_hi_r      <= s2_hi_r;
    end
  end

  // ------------------------------------------------------------ dividers
  logic [PIX_W-1:0] sat_q, hue_q;

  rhsv_div u_sat_div (
    .clk      (clk),
    .step_en  (en[LAST:PIPE_FRONT]),
    .dividend (s3_sat_dvd_r),
    .divisor  (s3_sat_dsr_r),
    .quotient (sat_q)
  );

  rhsv_div u_hue_div (
    .clk      (clk),
    .step_en  (en[LAST:PIPE_FRONT]),
    .dividend (s3_hue_dvd_r),
    .divisor  (s3_hue_dsr_r),
    .quotient (hue_q)
  );

  // Brightness rides alongside the divider stages
  logic [PIX_W-1:0] bri_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en[PIPE_FRONT]) begin
      bri_r[0] <= s3_hi_r;
    end
    for (int k = 1; k < DIV_STEPS; k++) begin
      if (en[PIPE_FRONT+k]) begin
        bri_r[k] <= bri_r[k-1];
      end
    end
  end

  assign out_beat.hue        = hue_q;
  assign out_beat.saturation = sat_q;
  assign out_beat.brightness = bri_r[DIV_STEPS-1];

  // ---------------------------------------------------------- assertions
  `RHSV_ASSERT_IMP(a_hue_range, clk, rst_n, out_beat.valid, out_beat.hue <= HUE_MAX)
  `RHSV_ASSERT_IMP(a_black_zero, clk, rst_n, out_beat.valid && out_beat.brightness == '0,
                   out_beat.saturation == '0 && out_beat.hue == '0)
  `RHSV_ASSERT_IMP(a_block_full, clk, rst_n, !in_beat.ready, &v_r)
  `RHSV_ASSERT_NXT(a_stall_holds, clk, rst_n, out_beat.valid && !out_beat.ready,
                   out_beat.valid && $stable({out_beat.hue, out_beat.saturation, out_beat.brightness}))

endmodule

[hdl/rhsv_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rhsv_pkg; caller guarantees the quotient fits in PIX_W bits.
module rhsv_div (
  input  logic                              clk,
  input  logic [rhsv_pkg::DIV_STEPS-1:0]    step_en,
  input  logic [rhsv_pkg::DVD_W-1:0]        dividend,
  input  logic [rhsv_pkg::PIX_W-1:0]        divisor,
  output logic [rhsv_pkg::PIX_W-1:0]        quotient
);
  import rhsv_pkg::*;

  // Partial remainder, unconsumed dividend bits with quotient bits shifted in
  typedef struct packed {
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] dsr;
  } div_stage_t;

  div_stage_t stg_r   [DIV_STEPS];
  div_stage_t stg_in  [DIV_STEPS];
  div_stage_t stg_nxt [DIV_STEPS];

  // Upper dividend half is already below the divisor, so it seeds the remainder
  assign stg_in[0] = '{rem: dividend[DVD_W-1:PIX_W], lo: dividend[PIX_W-1:0], dsr: divisor};

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [PIX_W:0] trial;
    logic [PIX_W:0] diff;
    logic           ge;

    if (k > 0) begin : g_link
      assign stg_in[k] = stg_r[k-1];
    end

    // Shift in one dividend bit, subtract when it fits
    always_comb begin
      trial = {stg_in[k].rem, stg_in[k].lo[PIX_W-1]};
      diff  = trial - {1'b0, stg_in[k].dsr};
      ge    = trial >= {1'b0, stg_in[k].dsr};
      stg_nxt[k].rem = ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
      stg_nxt[k].lo  = {stg_in[k].lo[PIX_W-2:0], ge};
      stg_nxt[k].dsr = stg_in[k].dsr;
    end

    always_ff @(posedge clk) begin
      if (step_en[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign quotient = stg_r[DIV_STEPS-1].lo;

endmodule

[tb/rhsv_hsv_checker.sv]
// Result checker for the RGB-to-HSV pixel converter: predicts the HSV beat for
// every accepted RGB beat and compares it with the next result beat.
// Depends on rhsv_pkg and the channel interfaces in rhsv_if.
module rhsv_hsv_checker (
  input  logic clk,
  input  logic rst_n,
  rhsv_rgb_if  rgb_mon,
  rhsv_hsv_if  hsv_mon,
  output int   mismatches,
  output int   in_flight,
  output int   results_checked,
  output int   input_stalls
);
  import rhsv_pkg::*;

  typedef logic [PIX_W-1:0] chan_t;

  // One predicted result, with the pixel it came from for messages
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t hue;
    chan_t saturation;
    chan_t brightness;
  } hsv_pred_t;

  hsv_pred_t hsv_pending [$];
  int        fail_total = 0;
  int        checked    = 0;
  int        stalls     = 0;

  assign mismatches      = fail_total;
  assign results_checked = checked;
  assign input_stalls    = stalls;

  // Exact integer HSV of one pixel
  function automatic hsv_pred_t hsv_of(input chan_t r, input chan_t g, input chan_t b);
    int        rv = r;
    int        gv = g;
    int        bv = b;
    int        hi;
    int        lo;
    int        span;
    int        num;
    hsv_pred_t res;
    hi   = (rv > gv) ? rv : gv;
    hi   = (hi > bv) ? hi : bv;
    lo   = (rv < gv) ? rv : gv;
    lo   = (lo < bv) ? lo : bv;
    span = hi - lo;
    res.red        = r;
    res.green      = g;
    res.blue       = b;
    res.brightness = chan_t'(hi);
    res.saturation = (hi == 0) ? '0 : chan_t'((255 * span) / hi);
    if (span == 0) begin
      res.hue = '0;
    end else begin
      // Largest channel picks the sector; red beats green beats blue on ties
      if (hi == rv) begin
        num = gv - bv;
        if (gv < bv) num += 6 * span;
      end else if (hi == gv) begin
        num = bv - rv + 2 * span;
      end else begin
        num = rv - gv + 4 * span;
      end
      res.hue = chan_t'((30 * num) / span);
    end
    return res;
  endfunction

  // Print and count one failure
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    fail_total++;
  endtask

  // Predict on input beats, compare on result beats
  always @(posedge clk) begin
    hsv_pred_t want;
    string     pix;
    if (rst_n) begin
      if (rgb_mon.valid && rgb_mon.ready)
        hsv_pending.push_back(hsv_of(rgb_mon.red, rgb_mon.green, rgb_mon.blue));
      if (rgb_mon.valid && !rgb_mon.ready)
        stalls++;
      if (hsv_mon.valid && hsv_mon.ready) begin
        if (hsv_pending.size() == 0) begin
          report_mismatch("result beat with nothing pending, brightness",
                          hsv_mon.brightness, -1);
        end else begin
          want = hsv_pending.pop_front();
          pix  = $sformatf("rgb %0d/%0d/%0d", want.red, want.green, want.blue);
          if (hsv_mon.hue !== want.hue)
            report_mismatch({"hue for ", pix}, hsv_mon.hue, want.hue);
          if (hsv_mon.saturation !== want.saturation)
            report_mismatch({"saturation for ", pix}, hsv_mon.saturation,
                            want.saturation);
          if (hsv_mon.brightness !== want.brightness)
            report_mismatch({"brightness for ", pix}, hsv_mon.brightness,
                            want.brightness);
        end
        checked++;
      end
      in_flight <= hsv_pending.size();
    end
  end

endmodule

[tb/tb.sv]
// Top of the RGB-to-HSV pixel converter testbench: clock, reset, pixel stimulus
// and result back-pressure in three idling phases, and the verdict.
// Depends on rhsv_pkg, rhsv_if, rgb_to_hsv_pixel_unit and rhsv_hsv_checker.
module tb;
  import rhsv_pkg::*;

  typedef logic [PIX_W-1:0] chan_t;

  localparam int PHASE_PIXELS = 630;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk      = 1'b0;
  logic rst_n;
  logic hold_req = 1'b0;
  int   tx_idle_pct = 25;
  int   rx_idle_pct = 77;
  int   cycle_count = 0;
  int   pixels_sent = 0;
  int   mismatches;
  int   in_flight;
  int   results_checked;
  int   input_stalls;

  rhsv_rgb_if rgb_bus ();
  rhsv_hsv_if hsv_bus ();

  rgb_to_hsv_pixel_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (rgb_bus),
    .out_beat (hsv_bus)
  );

  rhsv_hsv_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rgb_mon         (rgb_bus),
    .hsv_mon         (hsv_bus),
    .mismatches      (mismatches),
    .in_flight       (in_flight),
    .results_checked (results_checked),
    .input_stalls    (input_stalls)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at cycle limit %0d", CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random ready, or one long hold-off on request
  initial begin
    bit hold_done;
    hold_done     = 1'b0;
    hsv_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hsv_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        hsv_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one pixel beat; called and returns at a falling edge
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      rgb_bus.valid <= 1'b0;
      @(negedge clk);
    end
    rgb_bus.valid <= 1'b1;
    rgb_bus.red   <= r;
    rgb_bus.green <= g;
    rgb_bus.blue  <= b;
    @(posedge clk);
    while (!rgb_bus.ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  // Random pixel, weighted toward gray, dark, tied and clipped pixels
  task automatic pick_pixel(output chan_t r, output chan_t g, output chan_t b);
    int base;
    int v [3];
    base = $urandom_range(255);
    case ($urandom_range(5))
      0, 1: begin
        foreach (v[i]) v[i] = $urandom_range(255);
      end
      2: begin
        // near gray: tiny delta
        foreach (v[i]) begin
          v[i] = base + $urandom_range(4) - 2;
          if (v[i] < 0) v[i] = 0;
          if (v[i] > 255) v[i] = 255;
        end
      end
      3: begin
        foreach (v[i]) v[i] = $urandom_range(7);
      end
      4: begin
        // two channels tied, third random
        foreach (v[i]) v[i] = base;
        v[$urandom_range(2)] = $urandom_range(255);
      end
      default: begin
        foreach (v[i]) v[i] = $urandom_range(1) ? 255 : $urandom_range(255);
        v[$urandom_range(2)] = 0;
      end
    endcase
    r = chan_t'(v[0]);
    g = chan_t'(v[1]);
    b = chan_t'(v[2]);
  endtask

  // Stimulus and verdict
  initial begin
    chan_t r;
    chan_t g;
    chan_t b;
    rst_n         = 1'b0;
    rgb_bus.valid = 1'b0;
    rgb_bus.red   = '0;
    rgb_bus.green = '0;
    rgb_bus.blue  = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Corners: black, white, gray, primaries, wraparound, ties, tiny deltas
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd0,   8'd128, 8'd255);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd85,  8'd170, 8'd255);

    // Sender mostly busy, receiver mostly stalled
    repeat (PHASE_PIXELS) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end

    // Sender mostly idle, receiver mostly ready
    tx_idle_pct = 77;
    rx_idle_pct = 25;
    repeat (PHASE_PIXELS) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end

    // Full rate, opening with a long receiver hold-off to fill the pipeline
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    repeat (PHASE_PIXELS) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end
    rgb_bus.valid <= 1'b0;

    while (in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Converted %0d pixels (gray, black, tied, wraparound, random), %0d checked",
             pixels_sent, results_checked);
    $display("Input beats held back by a full pipeline for %0d cycles.", input_stalls);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
